@@ rtl/sgfs_pkg.sv @@
// shared constants for the savitzky-golay frame smoother
`timescale 1ns / 1ps
`default_nettype none

package sgfs_pkg;

    // result field widths
    localparam int SMOOTH_W = 17;
    localparam int POS_W    = 7;

    // 5-point quadratic kernel: -3, 12, 17, 12, -3 over 35
    localparam int C_CTR   = 17;
    localparam int C_NEAR  = 12;
    localparam int C_FAR   = 3;
    localparam int DIVISOR = 35;

    // frame indices with special handling
    localparam int K_HOLD  = 4;   // center of third position known, held
    localparam int K_BURST = 5;   // four leading positions go out

    // record queue between the divider and the output sequencer
    localparam int REC_DEPTH = 8;

    // index of the final beat within one record
    localparam logic [1:0] SUB_SINGLE = 2'd0;
    localparam logic [1:0] SUB_EDGE   = 2'd2;
    localparam logic [1:0] SUB_BURST  = 2'd3;

endpackage

`default_nettype wire

@@ rtl/sgfs_if.sv @@
// valid/ready channel interfaces for samples in and smoothed results out
`timescale 1ns / 1ps
`default_nettype none

interface sgfs_in_if #(
    parameter int SAMPLE_BITS = 16
) ();
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface sgfs_out_if
    import sgfs_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [SMOOTH_W-1:0] smoothed;
    logic [POS_W-1:0]    position;
    logic                frame_end;

    modport source (output valid, output smoothed, output position, output frame_end,
                    input ready);
    modport sink   (input valid, input smoothed, input position, input frame_end,
                    output ready);
endinterface

`default_nettype wire

@@ rtl/sgfs_div35.sv @@
// two-stage divide by 35 through an exact reciprocal multiply
`timescale 1ns / 1ps
`default_nettype none

module sgfs_div35
    import sgfs_pkg::*;
#(
    parameter int IN_W  = 22,
    parameter int TAG_W = 7
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    input  wire logic [IN_W-1:0]     i_mag,
    input  wire logic [TAG_W-1:0]    i_tag,
    output logic                     o_valid,
    output logic [SMOOTH_W-1:0]      o_quot,
    output logic [TAG_W-1:0]         o_tag
);

    // floor(x * m / 2^p) equals floor(x / 35) for every x below 2^IN_W
    localparam int SHIFT = IN_W + 6;
    localparam int M_W   = IN_W + 2;
    localparam int LO_W  = IN_W / 2;
    localparam int HI_W  = IN_W - LO_W;
    localparam int PL_W  = LO_W + M_W;
    localparam int PH_W  = HI_W + M_W;
    localparam int PS_W  = IN_W + M_W + 1;
    localparam logic [M_W-1:0] RECIP =
        M_W'(((64'd1 << SHIFT) + 64'(DIVISOR - 1)) / 64'(DIVISOR));

    logic              r_a_valid;
    logic [PL_W-1:0]   r_a_plo;
    logic [PH_W-1:0]   r_a_phi;
    logic [TAG_W-1:0]  r_a_tag;

    logic              r_b_valid;
    logic [SMOOTH_W-1:0] r_b_quot;
    logic [TAG_W-1:0]  r_b_tag;

    logic [PS_W-1:0]   w_prod;

    // stage a: two half-width partial products
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= i_valid;
        end
        r_a_plo <= PL_W'(i_mag[LO_W-1:0]) * PL_W'(RECIP);
        r_a_phi <= PH_W'(i_mag[IN_W-1:LO_W]) * PH_W'(RECIP);
        r_a_tag <= i_tag;
    end

    // recombine and keep the quotient bits
    assign w_prod = (PS_W'(r_a_phi) << LO_W) + PS_W'(r_a_plo);

    // stage b: quotient register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= r_a_valid;
        end
        r_b_quot <= SMOOTH_W'(w_prod >> SHIFT);
        r_b_tag  <= r_a_tag;
    end

    assign o_valid = r_b_valid;
    assign o_quot  = r_b_quot;
    assign o_tag   = r_b_tag;

endmodule

`default_nettype wire

@@ rtl/savgol_frame_smoother_top.sv @@
// 5-point quadratic savitzky-golay smoother over fixed-length frames
//
//  channel   dir  handshake      payload
//  i_in      in   valid/ready    sample [SAMPLE_BITS]
//  o_out     out  valid/ready    smoothed [17], position [7], frame_end
//
//  one sample is taken per cycle while i_in.ready is high; a frame of FRAME_LEN
//  samples gives FRAME_LEN results, one beat per cycle on the output side while
//  o_out.ready is high; a result passes through the kernel sum register, two divider
//  stages, the record queue, then the output register
//  the first sample past the leading edge of a frame releases four beats and the
//  last sample three; an 8-record queue absorbs these bursts
//  i_in.ready drops only when the queue plus the items in the pipeline reach 8
//  reset is synchronous and clears the frame index, pipeline valids and queue

`timescale 1ns / 1ps
`default_nettype none

module savgol_frame_smoother_top
    import sgfs_pkg::*;
#(
    parameter int FRAME_LEN   = 128,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    sgfs_in_if.sink     i_in,
    sgfs_out_if.source  o_out
);

    localparam int KW    = $clog2(FRAME_LEN);
    localparam int MAG_W = SAMPLE_BITS + 6;
    localparam int PTR_W = $clog2(REC_DEPTH);
    localparam int CNT_W = $clog2(REC_DEPTH + 1);
    localparam logic [KW-1:0] K_LAST = KW'(FRAME_LEN - 1);

    // sample window and frame position
    logic [SAMPLE_BITS-1:0] r_hist [5];
    logic [KW-1:0]          r_k;

    // kernel sum stage
    logic                   r_s1_valid;
    logic [MAG_W-1:0]       r_s1_mag;
    logic [KW-1:0]          r_s1_k;
    logic [MAG_W-1:0]       w_pos_sum;
    logic [MAG_W-1:0]       w_neg_sum;
    logic [MAG_W-1:0]       w_mag;

    // divider output
    logic                   w_d_valid;
    logic [SMOOTH_W-1:0]    w_d_quot;
    logic [KW-1:0]          w_d_k;

    // held edge values
    logic [SMOOTH_W-1:0]    r_held0;
    logic [SMOOTH_W-1:0]    r_held1;

    // record queue
    logic [SMOOTH_W-1:0]    r_rec_y    [REC_DEPTH];
    logic [SMOOTH_W-1:0]    r_rec_hold [REC_DEPTH];
    logic [KW-1:0]          r_rec_k    [REC_DEPTH];
    logic [PTR_W-1:0]       r_wr_ptr;
    logic [PTR_W-1:0]       r_rd_ptr;
    logic [CNT_W-1:0]       r_count;
    logic [CNT_W-1:0]       n_count;
    logic [1:0]             r_inflight;
    logic [1:0]             n_inflight;

    // output sequencer
    logic [1:0]             r_sub;
    logic [1:0]             n_sub;
    logic                   r_ov;
    logic [SMOOTH_W-1:0]    r_smoothed;
    logic [POS_W-1:0]       r_position;
    logic                   r_frame_end;

    logic                   w_ready;
    logic                   w_accept;
    logic                   w_push;
    logic                   w_load;
    logic                   w_pop;
    logic [KW-1:0]          w_h_k;
    logic                   w_h_burst;
    logic                   w_h_last;
    logic [1:0]             w_last_sub;
    logic [SMOOTH_W-1:0]    w_val;
    logic [POS_W-1:0]       w_pos;
    logic                   w_end;

    // room check covers every item already past the input
    assign w_ready  = ((CNT_W + 1)'(r_count) + (CNT_W + 1)'(r_inflight))
                      < (CNT_W + 1)'(REC_DEPTH);
    assign w_accept = i_in.valid && w_ready;
    assign i_in.ready = w_ready;

    // kernel sum over the window after this beat, clamped at zero
    assign w_pos_sum = MAG_W'(C_CTR) * MAG_W'(r_hist[3])
                     + MAG_W'(C_NEAR) * (MAG_W'(r_hist[2]) + MAG_W'(r_hist[4]));
    assign w_neg_sum = MAG_W'(C_FAR) * (MAG_W'(r_hist[1]) + MAG_W'(i_in.sample));
    assign w_mag     = (w_pos_sum < w_neg_sum) ? '0 : w_pos_sum - w_neg_sum;

    // window shift, frame index and sum register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 5; i++) begin
                r_hist[i] <= '0;
            end
            r_k        <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_accept;
            if (w_accept) begin
                for (int i = 0; i < 4; i++) begin
                    r_hist[i] <= r_hist[i+1];
                end
                r_hist[4] <= SAMPLE_BITS'(i_in.sample);
                r_k       <= (r_k == K_LAST) ? '0 : r_k + KW'(1);
            end
        end
        r_s1_mag <= w_mag;
        r_s1_k   <= r_k;
    end

    sgfs_div35 #(
        .IN_W  (MAG_W),
        .TAG_W (KW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s1_valid),
        .i_mag   (r_s1_mag),
        .i_tag   (r_s1_k),
        .o_valid (w_d_valid),
        .o_quot  (w_d_quot),
        .o_tag   (w_d_k)
    );

    // positions from the burst point on leave as records
    assign w_push = w_d_valid && (w_d_k >= KW'(K_BURST));

    // held values and record write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held0  <= '0;
            r_held1  <= '0;
            r_wr_ptr <= '0;
        end else begin
            if (w_d_valid && w_d_k == KW'(K_HOLD)) begin
                r_held0 <= w_d_quot;
            end
            if (w_d_valid && w_d_k >= KW'(K_HOLD)) begin
                r_held1 <= w_d_quot;
            end
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
        end
        if (w_push) begin
            r_rec_y[r_wr_ptr]    <= w_d_quot;
            r_rec_hold[r_wr_ptr] <= (w_d_k == KW'(K_BURST)) ? r_held0 : r_held1;
            r_rec_k[r_wr_ptr]    <= w_d_k;
        end
    end

    // expand the head record into its beats
    always_comb begin
        w_h_k      = r_rec_k[r_rd_ptr];
        w_h_burst  = (w_h_k == KW'(K_BURST));
        w_h_last   = (w_h_k == K_LAST);
        w_last_sub = w_h_burst ? SUB_BURST : (w_h_last ? SUB_EDGE : SUB_SINGLE);
        if (w_h_burst) begin
            w_pos = POS_W'(r_sub);
            w_val = (r_sub == 2'd1 || r_sub == 2'd2) ? r_rec_hold[r_rd_ptr]
                                                     : r_rec_y[r_rd_ptr];
        end else begin
            w_pos = POS_W'(w_h_k - KW'(2) + KW'(r_sub));
            w_val = (w_h_last && r_sub == SUB_EDGE) ? r_rec_hold[r_rd_ptr]
                                                    : r_rec_y[r_rd_ptr];
        end
        w_end  = w_h_last && (r_sub == SUB_EDGE);
        w_load = (r_count != '0) && (!r_ov || o_out.ready);
        w_pop  = w_load && (r_sub == w_last_sub);
        n_sub  = w_load ? (w_pop ? 2'd0 : r_sub + 2'd1) : r_sub;
        n_count    = r_count + CNT_W'(w_push) - CNT_W'(w_pop);
        n_inflight = r_inflight + 2'(w_accept) - 2'(w_d_valid);
    end

    // queue pointers, counts and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr   <= '0;
            r_count    <= '0;
            r_inflight <= '0;
            r_sub      <= '0;
            r_ov       <= 1'b0;
        end else begin
            r_count    <= n_count;
            r_inflight <= n_inflight;
            r_sub      <= n_sub;
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            if (w_load) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
        if (w_load) begin
            r_smoothed  <= w_val;
            r_position  <= w_pos;
            r_frame_end <= w_end;
        end
    end

    assign o_out.valid     = r_ov;
    assign o_out.smoothed  = r_smoothed;
    assign o_out.position  = r_position;
    assign o_out.frame_end = r_frame_end;

endmodule

`default_nettype wire

@@ rtl/sgfs_checker.sv @@
// port-level checks on the smoother output stream, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module sgfs_checker
    import sgfs_pkg::*;
#(
    parameter int FRAME_LEN = 128
) (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_out_valid,
    input wire logic                i_out_ready,
    input wire logic [SMOOTH_W-1:0] i_out_smoothed,
    input wire logic [POS_W-1:0]    i_out_position,
    input wire logic                i_out_frame_end
);

    localparam int KW = $clog2(FRAME_LEN);

    logic          w_beat;
    logic [KW-1:0] r_cnt;

    assign w_beat = i_out_valid && i_out_ready;

    // count output beats within the frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (w_beat) begin
            r_cnt <= (r_cnt == KW'(FRAME_LEN - 1)) ? '0 : r_cnt + KW'(1);
        end
    end

    // a stalled result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_smoothed)
            && $stable(i_out_position) && $stable(i_out_frame_end))
        else $error("stalled output result changed");

    // no result right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // positions run in frame order
    a_position: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_beat |-> i_out_position == POS_W'(r_cnt))
        else $error("output position out of sequence");

    // frame end flag only on the last position
    a_frame_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_beat |-> i_out_frame_end == (r_cnt == KW'(FRAME_LEN - 1)))
        else $error("frame end flag misplaced");

endmodule

bind savgol_frame_smoother_top sgfs_checker #(
    .FRAME_LEN (FRAME_LEN)
) u_sgfs_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_out_smoothed  (o_out.smoothed),
    .i_out_position  (o_out.position),
    .i_out_frame_end (o_out.frame_end)
);

`default_nettype wire

@@ sim/savgol_frame_smoother_top_test.sv @@
// self-checking testbench for the savitzky-golay frame smoother top level
`timescale 1ns / 1ps
`default_nettype none

module savgol_frame_smoother_top_test
    import sgfs_pkg::*;
();

    localparam int FRAME_LEN   = 128;
    localparam int SAMPLE_BITS = 16;
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int REPORT_MAX  = 10;

    typedef struct packed {
        logic [SMOOTH_W-1:0] smoothed;
        logic [POS_W-1:0]    position;
        logic                frame_end;
    } t_smooth_beat;

    logic i_clk = 1'b0;
    logic i_rst_n;

    sgfs_in_if #(.SAMPLE_BITS(SAMPLE_BITS)) sample_bus ();
    sgfs_out_if                             smooth_bus ();

    savgol_frame_smoother_top #(
        .FRAME_LEN   (FRAME_LEN),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (sample_bus),
        .o_out   (smooth_bus)
    );

    always #2 i_clk = ~i_clk;

    // predicted smoother state
    logic [SAMPLE_BITS-1:0] window [5];
    int                     frame_pos;
    logic [SMOOTH_W-1:0]    held_lead;
    logic [SMOOTH_W-1:0]    last_center;
    t_smooth_beat           expected_smoothed [$];

    int  mismatch_count = 0;
    int  idle_cycles    = 0;
    int  pressure_hold  = 0;
    bit  sender_idle    = 1'b0;
    bit  receiver_idle  = 1'b0;

    function automatic void queue_smoothed(logic [SMOOTH_W-1:0] value, int pos, logic last);
        t_smooth_beat beat;
        beat.smoothed  = value;
        beat.position  = POS_W'(pos);
        beat.frame_end = last;
        expected_smoothed.push_back(beat);
    endfunction

    // advance the window by one sample and queue the beats it releases
    function automatic void predict_smoothed(logic [SAMPLE_BITS-1:0] s);
        longint              kernel_sum;
        logic [SMOOTH_W-1:0] center;
        for (int i = 0; i < 4; i++) window[i] = window[i + 1];
        window[4] = s;
        if (frame_pos >= K_HOLD) begin
            kernel_sum = C_CTR * longint'(window[2])
                       + C_NEAR * (longint'(window[1]) + longint'(window[3]))
                       - C_FAR * (longint'(window[0]) + longint'(window[4]));
            center = (kernel_sum < 0) ? '0 : SMOOTH_W'(kernel_sum / DIVISOR);
            if (frame_pos == K_HOLD) begin
                held_lead = center;
            end else if (frame_pos == K_BURST) begin
                // leading edge: positions 0 and 3 mirror position 3, 1 and 2 mirror 2
                queue_smoothed(center, 0, 1'b0);
                queue_smoothed(held_lead, 1, 1'b0);
                queue_smoothed(held_lead, 2, 1'b0);
                queue_smoothed(center, 3, 1'b0);
            end else if (frame_pos == FRAME_LEN - 1) begin
                // trailing edge: last position copies the fourth from the end
                queue_smoothed(center, FRAME_LEN - 3, 1'b0);
                queue_smoothed(center, FRAME_LEN - 2, 1'b0);
                queue_smoothed(last_center, FRAME_LEN - 1, 1'b1);
            end else begin
                queue_smoothed(center, frame_pos - 2, 1'b0);
            end
            last_center = center;
        end
        frame_pos = (frame_pos == FRAME_LEN - 1) ? 0 : frame_pos + 1;
    endfunction

    // mix of full range, rails and small values so the clamp gets hit often
    function automatic logic [SAMPLE_BITS-1:0] rand_sample();
        case ($urandom_range(0, 3))
            0: return SAMPLE_BITS'($urandom);
            1: return $urandom_range(0, 1) ? '1 : '0;
            2: return SAMPLE_BITS'($urandom_range(0, 15));
            default: return '1 - SAMPLE_BITS'($urandom_range(0, 255));
        endcase
    endfunction

    // offer one sample beat, starting and ending just after a falling edge
    task automatic send_sample(input logic [SAMPLE_BITS-1:0] s);
        int gap;
        gap = sender_idle ? $urandom_range(0, 15) : 0;
        if (gap > 0) begin
            sample_bus.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        sample_bus.valid  <= 1'b1;
        sample_bus.sample <= s;
        do @(posedge i_clk); while (sample_bus.ready !== 1'b1);
        predict_smoothed(s);
        @(negedge i_clk);
    endtask

    // rails, clamp to zero, kernel maximum and alternating bits at frame start
    task automatic test_leading_edge();
        logic [SAMPLE_BITS-1:0] pattern [24];
        pattern = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000,
                    16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000,
                    16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'h5555,
                    16'hAAAA, 16'h0001, 16'hFFFE, 16'h8000, 16'h7FFF, 16'h0000};
        sender_idle   = 1'b1;
        receiver_idle = 1'b1;
        foreach (pattern[i]) send_sample(pattern[i]);
    endtask

    // rest of the first frame with random gaps, through the trailing edge
    task automatic test_frame_completion();
        do send_sample(rand_sample()); while (frame_pos != 0);
    endtask

    // back-to-back samples and an always-ready receiver
    task automatic test_full_rate();
        sender_idle   = 1'b0;
        receiver_idle = 1'b0;
        repeat (FRAME_LEN / 2) send_sample(rand_sample());
    endtask

    // receiver holds off for a long stretch while samples keep coming
    task automatic test_backpressure();
        pressure_hold = HOLD_CYCLES;
        repeat (FRAME_LEN / 2) send_sample(rand_sample());
    endtask

    // a whole frame with idling on both sides
    task automatic test_random_frame();
        sender_idle   = 1'b1;
        receiver_idle = 1'b1;
        repeat (FRAME_LEN) send_sample(rand_sample());
    endtask

    // result receiver with per-beat stalls
    initial begin : result_receiver
        int stall;
        smooth_bus.ready = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            stall = receiver_idle ? $urandom_range(0, 15) : 0;
            if (pressure_hold > 0) begin
                stall         = pressure_hold;
                pressure_hold = 0;
            end
            if (stall > 0) begin
                smooth_bus.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            smooth_bus.ready <= 1'b1;
            do @(posedge i_clk); while (smooth_bus.valid !== 1'b1);
            @(negedge i_clk);
        end
    end

    // compare each accepted result beat against the oldest prediction
    always @(posedge i_clk) begin
        t_smooth_beat want;
        if (i_rst_n && smooth_bus.valid && smooth_bus.ready) begin
            if (expected_smoothed.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX)
                    $display("unexpected beat: smoothed %0d position %0d frame_end %0b",
                             smooth_bus.smoothed, smooth_bus.position, smooth_bus.frame_end);
            end else begin
                want = expected_smoothed.pop_front();
                if (smooth_bus.smoothed !== want.smoothed
                        || smooth_bus.position !== want.position
                        || smooth_bus.frame_end !== want.frame_end) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                        $display("beat differs: expected %0d/%0d/%0b got %0d/%0d/%0b",
                                 want.smoothed, want.position, want.frame_end,
                                 smooth_bus.smoothed, smooth_bus.position,
                                 smooth_bus.frame_end);
                end
            end
        end
    end

    // watchdog on cycles without any accepted beat
    always @(posedge i_clk) begin
        if ((sample_bus.valid && sample_bus.ready) || (smooth_bus.valid && smooth_bus.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("savgol_frame_smoother_top: mismatch");
            $finish;
        end
    end

    // reset, run the tests in turn, drain and report
    initial begin
        i_rst_n           = 1'b0;
        sample_bus.valid  = 1'b0;
        sample_bus.sample = '0;
        foreach (window[i]) window[i] = '0;
        frame_pos   = 0;
        held_lead   = '0;
        last_center = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_leading_edge();
        test_frame_completion();
        test_full_rate();
        test_backpressure();
        test_random_frame();

        sample_bus.valid <= 1'b0;
        wait (expected_smoothed.size() == 0);
        repeat (16) @(negedge i_clk);
        if (mismatch_count == 0 && expected_smoothed.size() == 0) begin
            $display("savgol_frame_smoother_top: match");
        end else begin
            $display("savgol_frame_smoother_top: mismatch");
        end
        $finish;
    end

endmodule

`default_nettype wire

@@ savgol_frame_smoother_top.f @@
rtl/sgfs_pkg.sv
rtl/sgfs_if.sv
rtl/sgfs_div35.sv
rtl/savgol_frame_smoother_top.sv
rtl/sgfs_checker.sv
sim/savgol_frame_smoother_top_test.sv
